// ===== src/bootloader_host_sequencer_top_assert.svh =====
// Assertion macros shared by the checker of the bootloader host sequencer.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef BOOTLOADER_HOST_SEQUENCER_TOP_ASSERT_SVH
`define BOOTLOADER_HOST_SEQUENCER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BHS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bhs check failed");

// Consequent must hold in the cycle after the antecedent.
`define BHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bhs check failed");

`endif

// ===== src/bhs_pkg.sv =====
package bhs_pkg;

  localparam int unsigned MAX_RES = 5;
  localparam logic [8:0] MAX_BLOCK = 9'd256;

  // Request codes.
  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_GO    = 3'd1;
  localparam logic [2:0] REQ_ERASE = 3'd2;
  localparam logic [2:0] REQ_DATA  = 3'd3;
  localparam logic [2:0] REQ_RX    = 3'd4;
  localparam logic [2:0] REQ_TICK  = 3'd5;

  // Operations.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_GO    = 2'd1;
  localparam logic [1:0] OP_ERASE = 2'd2;

  // Result kinds and outcomes.
  localparam logic       KIND_TX     = 1'b0;
  localparam logic       KIND_FINISH = 1'b1;
  localparam logic [1:0] OC_OK       = 2'd0;
  localparam logic [1:0] OC_REJECT   = 2'd1;
  localparam logic [1:0] OC_TIMEOUT  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ACK_CODE      = 3'd0;
  localparam logic [2:0] CFG_WRITE_OPCODE  = 3'd1;
  localparam logic [2:0] CFG_GO_OPCODE     = 3'd2;
  localparam logic [2:0] CFG_ERASE_OPCODE  = 3'd3;
  localparam logic [2:0] CFG_EXT_OPCODE    = 3'd4;
  localparam logic [2:0] CFG_SHORT_TIMEOUT = 3'd5;
  localparam logic [2:0] CFG_WRITE_TIMEOUT = 3'd6;
  localparam logic [2:0] CFG_ERASE_TIMEOUT = 3'd7;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CMD_ACK,
    PH_ADDR_ACK,
    PH_DATA,
    PH_DATA_ACK,
    PH_EXT_ARG_ACK,
    PH_ERASE_DONE
  } phase_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] target_address;
    logic [8:0]  block_length;
    logic [7:0]  byte_value;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] tx_byte;
    logic [1:0] outcome;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  ack_code;
    logic [7:0]  write_opcode;
    logic [7:0]  go_opcode;
    logic [7:0]  erase_opcode;
    logic [7:0]  ext_erase_opcode;
    logic [15:0] short_timeout;
    logic [15:0] write_timeout;
    logic [15:0] erase_timeout;
  } cfg_t;

  // One result before run_last is attached.
  typedef struct packed {
    logic       kind;
    logic [7:0] tx;
    logic [1:0] oc;
  } entry_t;

  // All results caused by one item.
  typedef struct packed {
    logic [2:0]               cnt;
    entry_t [MAX_RES-1:0]     ent;
  } burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic entry_t tx_entry(input logic [7:0] b);
    entry_t e;
    e.kind = KIND_TX;
    e.tx   = b;
    e.oc   = OC_OK;
    return e;
  endfunction

  function automatic entry_t fin_entry(input logic [1:0] oc);
    entry_t e;
    e.kind = KIND_FINISH;
    e.tx   = 8'h00;
    e.oc   = oc;
    return e;
  endfunction

endpackage

// ===== src/bootloader_host_sequencer_top.sv =====
// First result path: the item's results go into the result queue, then into cur_r.
// Throughput: one item a cycle is accepted while the two-entry result queue has room;
// one result a cycle leaves while out_stall is low; an item yields 1 to 5 results.
// Items that cause no result are not queued and never reach the output.
// Reset: synchronous, active low; the sequencer returns to idle, the queue empties
// and the configuration registers take their default values.
module bootloader_host_sequencer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bhs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bhs_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import bhs_pkg::*;

  q_status_t q_status;
  burst_t    push_burst, pop_burst;
  logic      push, pop, acc;

  assign in_stall  = q_status.full;
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  bhs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .in_item    (in_item),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_burst (push_burst)
  );

  bhs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_burst (push_burst),
    .pop        (pop),
    .pop_burst  (pop_burst),
    .status     (q_status)
  );

  bhs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_burst   (pop_burst),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== src/bhs_front.sv =====
module bhs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  bhs_pkg::in_item_t in_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              push,
  output bhs_pkg::burst_t   push_burst
);
  import bhs_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  op_r, op_nxt;
  logic        fb_r, fb_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [8:0]  left_r, left_nxt;
  logic [7:0]  xor_r, xor_nxt;
  cfg_t        cfg_r, cfg_nxt;

  logic        is_start, is_data, is_rx, is_tick;
  logic        waiting, wait_ev, ok;
  logic [1:0]  fail_oc;
  logic [15:0] ticks_inc, tmo;
  logic [8:0]  len_clamp;
  logic [7:0]  xor_data, addr_xor, start_op;
  burst_t      burst;

  assign is_start = acc && (in_item.req_type == REQ_WRITE || in_item.req_type == REQ_GO ||
                            in_item.req_type == REQ_ERASE) && phase_r == PH_IDLE;
  assign is_data  = acc && in_item.req_type == REQ_DATA && phase_r == PH_DATA;
  assign waiting  = phase_r == PH_CMD_ACK || phase_r == PH_ADDR_ACK ||
                    phase_r == PH_DATA_ACK || phase_r == PH_EXT_ARG_ACK ||
                    phase_r == PH_ERASE_DONE;
  assign is_rx    = acc && in_item.req_type == REQ_RX && waiting;
  assign is_tick  = acc && in_item.req_type == REQ_TICK && waiting;

  assign ticks_inc = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;
  assign tmo = (phase_r == PH_DATA_ACK)   ? cfg_r.write_timeout :
               (phase_r == PH_ERASE_DONE) ? cfg_r.erase_timeout : cfg_r.short_timeout;

  assign ok      = is_rx && in_item.byte_value == cfg_r.ack_code;
  assign fail_oc = is_rx ? OC_REJECT : OC_TIMEOUT;
  assign wait_ev = is_rx || (is_tick && ticks_inc >= tmo);

  assign len_clamp = (in_item.block_length == 9'd0)     ? 9'd1 :
                     (in_item.block_length > MAX_BLOCK) ? MAX_BLOCK : in_item.block_length;
  assign xor_data  = xor_r ^ in_item.byte_value;
  assign addr_xor  = addr_r[31:24] ^ addr_r[23:16] ^ addr_r[15:8] ^ addr_r[7:0];
  assign start_op  = (in_item.req_type == REQ_WRITE) ? cfg_r.write_opcode :
                     (in_item.req_type == REQ_GO)    ? cfg_r.go_opcode : cfg_r.ext_erase_opcode;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ACK_CODE:      cfg_nxt.ack_code         = cfg_data[7:0];
        CFG_WRITE_OPCODE:  cfg_nxt.write_opcode     = cfg_data[7:0];
        CFG_GO_OPCODE:     cfg_nxt.go_opcode        = cfg_data[7:0];
        CFG_ERASE_OPCODE:  cfg_nxt.erase_opcode     = cfg_data[7:0];
        CFG_EXT_OPCODE:    cfg_nxt.ext_erase_opcode = cfg_data[7:0];
        CFG_SHORT_TIMEOUT: cfg_nxt.short_timeout    = cfg_data;
        CFG_WRITE_TIMEOUT: cfg_nxt.write_timeout    = cfg_data;
        CFG_ERASE_TIMEOUT: cfg_nxt.erase_timeout    = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    fb_nxt    = fb_r;
    ticks_nxt = ticks_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    xor_nxt   = xor_r;
    if (is_start) begin
      op_nxt    = in_item.req_type[1:0];
      fb_nxt    = 1'b0;
      addr_nxt  = in_item.target_address;
      if (in_item.req_type == REQ_WRITE) begin
        left_nxt = len_clamp;
      end
      phase_nxt = PH_CMD_ACK;
      ticks_nxt = 16'd0;
    end
    if (is_data) begin
      xor_nxt  = xor_data;
      left_nxt = left_r - 9'd1;
      if (left_r == 9'd1) begin
        phase_nxt = PH_DATA_ACK;
        ticks_nxt = 16'd0;
      end
    end
    if (is_tick) begin
      ticks_nxt = ticks_inc;
    end
    if (wait_ev) begin
      case (phase_r)
        PH_CMD_ACK: begin
          if (op_r == OP_ERASE && !fb_r && !ok) begin
            fb_nxt    = 1'b1;
            ticks_nxt = 16'd0;
          end else if (!ok) begin
            phase_nxt = PH_IDLE;
          end else if (op_r == OP_ERASE) begin
            phase_nxt = fb_r ? PH_ERASE_DONE : PH_EXT_ARG_ACK;
            ticks_nxt = 16'd0;
          end else begin
            phase_nxt = PH_ADDR_ACK;
            ticks_nxt = 16'd0;
          end
        end
        PH_ADDR_ACK: begin
          if (!ok || op_r == OP_GO) begin
            phase_nxt = PH_IDLE;
          end else begin
            xor_nxt   = left_r[7:0] - 8'd1;
            phase_nxt = PH_DATA;
            ticks_nxt = 16'd0;
          end
        end
        PH_EXT_ARG_ACK: begin
          if (!ok) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_ERASE_DONE;
            ticks_nxt = 16'd0;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Results caused by the accepted item.
  always_comb begin
    burst = '0;
    if (is_start) begin
      burst.cnt    = 3'd2;
      burst.ent[0] = tx_entry(start_op);
      burst.ent[1] = tx_entry(~start_op);
    end
    if (is_data) begin
      burst.cnt    = (left_r == 9'd1) ? 3'd2 : 3'd1;
      burst.ent[0] = tx_entry(in_item.byte_value);
      burst.ent[1] = tx_entry(xor_data);
    end
    if (wait_ev) begin
      case (phase_r)
        PH_CMD_ACK: begin
          if (op_r == OP_ERASE && !fb_r && !ok) begin
            burst.cnt    = 3'd2;
            burst.ent[0] = tx_entry(cfg_r.erase_opcode);
            burst.ent[1] = tx_entry(~cfg_r.erase_opcode);
          end else if (!ok) begin
            burst.cnt    = 3'd1;
            burst.ent[0] = fin_entry(fail_oc);
          end else if (op_r == OP_ERASE) begin
            burst.ent[0] = tx_entry(8'hFF);
            if (!fb_r) begin
              burst.cnt    = 3'd3;
              burst.ent[1] = tx_entry(8'hFF);
              burst.ent[2] = tx_entry(8'h00);
            end else begin
              burst.cnt    = 3'd2;
              burst.ent[1] = tx_entry(8'h00);
            end
          end else begin
            burst.cnt    = 3'd5;
            burst.ent[0] = tx_entry(addr_r[31:24]);
            burst.ent[1] = tx_entry(addr_r[23:16]);
            burst.ent[2] = tx_entry(addr_r[15:8]);
            burst.ent[3] = tx_entry(addr_r[7:0]);
            burst.ent[4] = tx_entry(addr_xor);
          end
        end
        PH_ADDR_ACK: begin
          burst.cnt = 3'd1;
          if (!ok) begin
            burst.ent[0] = fin_entry(fail_oc);
          end else if (op_r == OP_GO) begin
            burst.ent[0] = fin_entry(OC_OK);
          end else begin
            burst.ent[0] = tx_entry(left_r[7:0] - 8'd1);
          end
        end
        PH_EXT_ARG_ACK: begin
          if (!ok) begin
            burst.cnt    = 3'd1;
            burst.ent[0] = fin_entry(fail_oc);
          end
        end
        default: begin
          burst.cnt    = 3'd1;
          burst.ent[0] = fin_entry(ok ? OC_OK : fail_oc);
        end
      endcase
    end
  end

  assign push       = burst.cnt != 3'd0;
  assign push_burst = burst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= OP_WRITE;
      fb_r    <= 1'b0;
      ticks_r <= 16'd0;
      addr_r  <= 32'd0;
      left_r  <= 9'd0;
      xor_r   <= 8'd0;
      cfg_r.ack_code         <= 8'd121;
      cfg_r.write_opcode     <= 8'd49;
      cfg_r.go_opcode        <= 8'd33;
      cfg_r.erase_opcode     <= 8'd67;
      cfg_r.ext_erase_opcode <= 8'd68;
      cfg_r.short_timeout    <= 16'd1000;
      cfg_r.write_timeout    <= 16'd3000;
      cfg_r.erase_timeout    <= 16'd20000;
    end else begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      fb_r    <= fb_nxt;
      ticks_r <= ticks_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      xor_r   <= xor_nxt;
      cfg_r   <= cfg_nxt;
    end
  end

endmodule

// ===== src/bhs_queue.sv =====
module bhs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bhs_pkg::burst_t     push_burst,
  input  logic                pop,
  output bhs_pkg::burst_t     pop_burst,
  output bhs_pkg::q_status_t  status
);
  import bhs_pkg::*;

  burst_t     slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign status.full  = cnt_r == 2'd2;
  assign status.empty = cnt_r == 2'd0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_burst    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/bhs_back.sv =====
module bhs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bhs_pkg::q_status_t  q_status,
  input  bhs_pkg::burst_t     q_burst,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bhs_pkg::out_item_t  out_item
);
  import bhs_pkg::*;

  burst_t     cur_r, cur_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       last, take;
  entry_t     ent;

  assign last = idx_r == (cur_r.cnt - 3'd1);
  assign take = busy_r && !out_stall;
  // The next burst loads in the cycle the last result of the current one leaves.
  assign pop  = !q_status.empty && (!busy_r || (take && last));

  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (pop) begin
      cur_nxt  = q_burst;
      idx_nxt  = 3'd0;
      busy_nxt = 1'b1;
    end else if (take && last) begin
      busy_nxt = 1'b0;
    end else if (take) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  assign ent                  = cur_r.ent[idx_r];
  assign out_valid            = busy_r;
  assign out_item.result_kind = ent.kind;
  assign out_item.tx_byte     = ent.tx;
  assign out_item.outcome     = ent.oc;
  assign out_item.run_last    = last;

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 3'd0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== src/bhs_checker.sv =====
`include "bootloader_host_sequencer_top_assert.svh"

module bhs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input bhs_pkg::out_item_t out_item
);
  import bhs_pkg::*;

  `BHS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  // A finish result always closes the run of results of its item.
  `BHS_ASSERT_NOW(a_fin_last, out_valid && out_item.result_kind == KIND_FINISH, out_item.run_last && out_item.tx_byte == 8'h00)
  `BHS_ASSERT_NOW(a_tx_ok, out_valid && out_item.result_kind == KIND_TX, out_item.outcome == OC_OK)
  `BHS_ASSERT_NOW(a_oc_legal, out_valid, out_item.outcome == OC_OK || out_item.outcome == OC_REJECT || out_item.outcome == OC_TIMEOUT)

endmodule

bind bootloader_host_sequencer_top bhs_checker u_bhs_checker (.*);
